// ===== sv/ucl_pkg.sv =====
// ----------------------------------------------------------------------------
// ucl_pkg: shared types and constants of the utf-8 cyrillic lowercaser
// byte codes used for case folding and the result bundle that moves from the
// scan stage through the bundle queue to the output serializer
// ----------------------------------------------------------------------------
package ucl_pkg;

  localparam int unsigned BundleBytes = 4;

  localparam logic [7:0] AsciiLimit   = 8'h80;
  localparam logic [7:0] AsciiUpperA  = 8'h41;
  localparam logic [7:0] AsciiUpperZ  = 8'h5A;
  localparam logic [7:0] CaseOffset   = 8'h20;
  localparam logic [7:0] CyrLeadLo    = 8'hD0;
  localparam logic [7:0] CyrLeadHi    = 8'hD1;
  localparam logic [7:0] CyrUpperLo   = 8'h90;
  localparam logic [7:0] CyrUpperLoEn = 8'h9F;
  localparam logic [7:0] CyrUpperHi   = 8'hA0;
  localparam logic [7:0] CyrUpperHiEn = 8'hAF;
  localparam logic [7:0] CyrUpperIo   = 8'h81;
  localparam logic [7:0] CyrLowerIo   = 8'h91;
  localparam logic [7:0] Lead4Mask    = 8'hF0;
  localparam logic [7:0] Lead3Mask    = 8'hE0;

  // lowercased bytes produced by one accepted request
  typedef struct packed {
    logic [BundleBytes-1:0][7:0] bytes;
    logic [2:0]                  cnt;   // 1..4 valid bytes, first in bytes[0]
    logic                        last;  // final byte closes the token
  } ucl_bundle_t;

endpackage

// ===== sv/ucl_front.sv =====
// ----------------------------------------------------------------------------
// ucl_front: byte scan and group holding
// joins held bytes with the new byte, folds what can be decided and keeps the
// tail of an incomplete group for the next request
// ----------------------------------------------------------------------------
module ucl_front
  import ucl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  in_byte_i,
  input  logic        token_end_i,
  output ucl_bundle_t bundle_o,
  output logic        bundle_valid_o
);

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      held_count_q, held_count_d;

  logic [3:0][7:0] buf_w;
  logic [2:0]      n_w, p_w, k_w, q_w, len_w, idx_w, src_w;
  logic [7:0]      c_w, c2_w;
  logic            stop_w;
  logic [3:0][7:0] obytes_w;

  function automatic logic [2:0] lead_len(input logic [7:0] c);
    if ((c & Lead4Mask) == Lead4Mask) begin
      return 3'd4;
    end else if ((c & Lead3Mask) == Lead3Mask) begin
      return 3'd3;
    end else begin
      return 3'd2;
    end
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      buf_w[i] = (2'(i) < held_count_q) ? held_q[i] : in_byte_i;
    end
    buf_w[3] = in_byte_i;
    n_w      = {1'b0, held_count_q} + 3'd1;
    p_w      = '0;
    k_w      = '0;
    stop_w   = 1'b0;
    obytes_w = '0;
    c_w      = '0;
    c2_w     = '0;
    q_w      = '0;
    len_w    = '0;
    idx_w    = '0;
    src_w    = '0;
    // at most four positions, each pass consumes at least one byte or stops
    for (int it = 0; it < 4; it++) begin
      if (!stop_w && (p_w < n_w)) begin
        c_w   = buf_w[p_w[1:0]];
        q_w   = p_w + 3'd1;
        c2_w  = buf_w[q_w[1:0]];
        len_w = lead_len(c_w);
        if (c_w < AsciiLimit) begin
          obytes_w[k_w[1:0]] = (c_w >= AsciiUpperA && c_w <= AsciiUpperZ) ?
                               c_w + CaseOffset : c_w;
          k_w = k_w + 3'd1;
          p_w = p_w + 3'd1;
        end else if (c_w == CyrLeadLo && q_w < n_w &&
                     c2_w >= CyrUpperLo && c2_w <= CyrUpperLoEn) begin
          obytes_w[k_w[1:0]] = CyrLeadLo;
          idx_w = k_w + 3'd1;
          obytes_w[idx_w[1:0]] = c2_w + CaseOffset;
          k_w = k_w + 3'd2;
          p_w = p_w + 3'd2;
        end else if (c_w == CyrLeadLo && q_w < n_w &&
                     c2_w >= CyrUpperHi && c2_w <= CyrUpperHiEn) begin
          obytes_w[k_w[1:0]] = CyrLeadHi;
          idx_w = k_w + 3'd1;
          obytes_w[idx_w[1:0]] = c2_w - CaseOffset;
          k_w = k_w + 3'd2;
          p_w = p_w + 3'd2;
        end else if (c_w == CyrLeadLo && q_w < n_w && c2_w == CyrUpperIo) begin
          obytes_w[k_w[1:0]] = CyrLeadHi;
          idx_w = k_w + 3'd1;
          obytes_w[idx_w[1:0]] = CyrLowerIo;
          k_w = k_w + 3'd2;
          p_w = p_w + 3'd2;
        end else if (p_w + len_w <= n_w) begin
          // complete group, copied unchanged
          for (int j = 0; j < 4; j++) begin
            if (3'(j) < len_w) begin
              idx_w = k_w + 3'(j);
              src_w = p_w + 3'(j);
              obytes_w[idx_w[1:0]] = buf_w[src_w[1:0]];
            end
          end
          k_w = k_w + len_w;
          p_w = p_w + len_w;
        end else if (token_end_i) begin
          // token cut inside a group: lead alone, rest rescanned
          obytes_w[k_w[1:0]] = c_w;
          k_w = k_w + 3'd1;
          p_w = p_w + 3'd1;
        end else begin
          stop_w = 1'b1;
        end
      end
    end
  end

  always_comb begin
    held_d = held_q;
    for (int i = 0; i < 3; i++) begin
      if ((p_w + 3'(i)) < n_w) begin
        held_d[i] = buf_w[2'(p_w + 3'(i))];
      end
    end
    held_count_d = token_end_i ? 2'd0 : 2'(n_w - p_w);
  end

  assign bundle_o.bytes = obytes_w;
  assign bundle_o.cnt   = k_w;
  assign bundle_o.last  = token_end_i;
  assign bundle_valid_o = accept_i && (k_w != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= '0;
    end else if (accept_i) begin
      held_count_q <= held_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

  a_held_is_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_count_q != 2'd0 |-> held_q[0][7])
    else $error("held group does not start with a lead byte");

  a_end_flushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && token_end_i |=> held_count_q == 2'd0)
    else $error("bytes still held after end of token");

  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && token_end_i |-> bundle_valid_o)
    else $error("end of token produced no byte");

endmodule

// ===== sv/ucl_queue.sv =====
// ----------------------------------------------------------------------------
// ucl_queue: bundle queue
// small register queue between the scan stage and the output serializer
// ----------------------------------------------------------------------------
module ucl_queue
  import ucl_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ucl_bundle_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output ucl_bundle_t head_o,
  output logic        empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  ucl_bundle_t           mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("bundle pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("bundle popped from empty queue");

endmodule

// ===== sv/ucl_back.sv =====
// ----------------------------------------------------------------------------
// ucl_back: output serializer
// walks the head bundle one byte per request and retires it after its last byte
// ----------------------------------------------------------------------------
module ucl_back
  import ucl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ucl_bundle_t head_i,
  input  logic        head_empty_i,
  output logic        head_pop_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  out_byte_o,
  output logic        out_end_o
);

  logic [1:0] idx_q, idx_d;
  logic       at_last;
  logic       take;

  assign at_last    = (({1'b0, idx_q} + 3'd1) == head_i.cnt);
  assign empty_o    = head_empty_i;
  assign take       = pop_i && !head_empty_i;
  assign head_pop_o = take && at_last;
  assign out_byte_o = head_i.bytes[idx_q];
  assign out_end_o  = head_i.last && at_last;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = at_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_head_not_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_empty_i |-> head_i.cnt != 3'd0)
    else $error("queued bundle holds no byte");

  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_empty_i |-> ({1'b0, idx_q} < head_i.cnt))
    else $error("byte index past end of bundle");

endmodule

// ===== sv/utf8_cyrillic_lowercaser.sv =====
// ----------------------------------------------------------------------------
// utf8_cyrillic_lowercaser: streaming utf-8 lowercaser for ascii and cyrillic
// folds a token given one byte per request into its lowercased byte stream
// ----------------------------------------------------------------------------
// input channel: a request is taken at a clock edge with push high and full
//   low; it carries one raw byte and a flag marking the token's last byte
// output channel: while empty is low the oldest byte waits on out_byte_o and
//   out_end_o; it is taken at an edge with pop high
// the scan stage joins up to three held bytes with the new byte, folds what
//   can be decided (ascii A-Z, cyrillic d0 90..af and d0 81) and holds the
//   tail of an unfinished multi-byte group; the 1 to 4 bytes of one request
//   go as one bundle into a queue of QueueDepth bundles
// throughput: one input request per cycle while the queue has room; the
//   serializer sends one byte per cycle while pop is high and walks each
//   bundle byte by byte; over a token bytes in equal bytes out
// queueing: a decided byte enters the bundle queue with its request; bytes of an
//   unfinished group wait until the group completes or the token ends
// end of token: everything held is flushed, a cut group sends its lead alone
//   and rescans the rest; out_end_o marks the final byte
// a stalled receiver fills the queue and then full holds off new requests
// reset clears the held count, the queue and the serializer; no bytes remain
// ----------------------------------------------------------------------------
module utf8_cyrillic_lowercaser
  import ucl_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       token_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       out_end_o
);

  logic        accept;
  ucl_bundle_t scan_bundle;
  logic        scan_valid;
  ucl_bundle_t head_bundle;
  logic        head_empty;
  logic        head_pop;

  // a request is taken whenever the queue has a free bundle slot
  assign accept = push && !full;

  ucl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .token_end_i    (token_end_i),
    .bundle_o       (scan_bundle),
    .bundle_valid_o (scan_valid)
  );

  // requests that only extend a held group push nothing
  ucl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (scan_valid),
    .push_data_i (scan_bundle),
    .full_o      (full),
    .pop_i       (head_pop),
    .head_o      (head_bundle),
    .empty_o     (head_empty)
  );

  ucl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_bundle),
    .head_empty_i (head_empty),
    .head_pop_o   (head_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_byte_o   (out_byte_o),
    .out_end_o    (out_end_o)
  );

endmodule
